[src/gitm_pkg.sv]
package gitm_pkg;

  localparam int BoxW = 16;
  localparam int AreaW = 34;     // signed area of a box, 17x17 signed product
  localparam int InterW = 32;    // unsigned intersection area
  localparam int UnionW = 35;    // signed union
  localparam int CostW = 17;
  localparam int QBits = 17;     // quotient bits of inter*65536/union (0..65536)

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_MATCH = 2'd1,
    OP_END   = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef struct packed {
    logic [BoxW-1:0] l;
    logic [BoxW-1:0] t;
    logic [BoxW-1:0] r;
    logic [BoxW-1:0] b;
  } box_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_AREA,
    ST_DIV,
    ST_PICK,
    ST_DONE,
    ST_OUT
  } state_t;

  // control between sequencer and divider
  typedef struct packed {
    logic start;
  } div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

[src/gitm_divider.sv]
module gitm_divider
  import gitm_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  div_ctrl_t                ctrl,
  input  logic [InterW-1:0]        inter,
  input  logic [UnionW-2:0]        union_val,
  output div_stat_t                stat,
  output logic [QBits-1:0]         quot
);

  // restoring divider, one quotient bit per cycle of inter*65536 / union
  localparam int RemW = UnionW;
  localparam int NumW = InterW + 16;
  localparam int CntW = $clog2(NumW + 1);

  logic [RemW-1:0] rem;
  logic [NumW-1:0] num;
  logic [CntW-1:0] cnt;
  logic            busy;
  logic            done;
  logic [RemW-1:0] trial;
  logic            fits;

  assign trial = {rem[RemW-2:0], num[NumW-1]};
  assign fits  = trial >= {1'b0, union_val};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctrl.start) begin
        busy <= 1'b1;
        rem  <= '0;
        num  <= {inter, 16'd0};
        cnt  <= CntW'(NumW);
      end else if (busy) begin
        rem  <= fits ? trial - {1'b0, union_val} : trial;
        num  <= {num[NumW-2:0], fits};
        cnt  <= cnt - 1'b1;
        if (cnt == CntW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign stat = '{busy: busy, done: done};
  assign quot = num[QBits-1:0];

endmodule

[src/greedy_iou_track_matcher_unit.sv]
// Greedy IoU track matcher.
// Input channel (in_valid/in_stall) carries one request: op 0 stores a
// detection box and class, op 1 presents a track, op 2 ends the frame.
// Output channel (out_valid/out_stall) returns at most one match per
// track request: track id, detection index and cost = 1 - IoU in Q1.16.
// iou_threshold is written through cfg_we/cfg_data; the user must write it
// only while idle, as the block itself does not enforce this. Loads and
// frame ends can follow back to back. A track request scans every stored
// detection; a same-class unused candidate with a positive union goes
// through the shared restoring divider (48 quotient steps plus setup);
// other entries skip it.
// The result sits in an output register; while out_stall is high the
// block holds it and accepts no new request.
// Reset clears the detection count and used marks and sets the threshold to 32768.
module greedy_iou_track_matcher_unit
  import gitm_pkg::*;
#(
  parameter int MAX_DETECTIONS = 64
)(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         op,
  input  logic [7:0]         obj_class,
  input  logic [15:0]        box_left,
  input  logic [15:0]        box_top,
  input  logic [15:0]        box_right,
  input  logic [15:0]        box_bottom,
  input  logic [15:0]        track_ident,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [15:0]        matched_track,
  output logic [5:0]         matched_detection,
  output logic [16:0]        match_cost,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_data
);

  localparam int IdxW = (MAX_DETECTIONS > 1) ? $clog2(MAX_DETECTIONS) : 1;
  localparam int CntW = $clog2(MAX_DETECTIONS + 1);

  // store
  logic [7:0]  cls_mem [MAX_DETECTIONS];
  box_t        box_mem [MAX_DETECTIONS];
  logic [MAX_DETECTIONS-1:0] used;
  logic [CntW-1:0] count;
  logic [15:0] thresh;

  state_t state, state_next;
  logic [CntW-1:0] scan;
  logic [IdxW-1:0] rd_addr;
  logic [7:0]  rd_cls;
  box_t        rd_box;
  logic        rd_used;
  box_t        trk;
  logic [7:0]  trk_cls;
  logic [15:0] trk_id;
  logic        found;
  logic [IdxW-1:0] win_idx;
  logic [CostW-1:0] win_cost;
  logic [InterW-1:0] inter;
  logic signed [UnionW-1:0] uni;
  logic        uni_pos;
  div_ctrl_t   dctl;
  div_stat_t   dst;
  logic [QBits-1:0] quot;
  logic [CostW-1:0] cost;
  logic        accept;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != ST_IDLE);

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) thresh <= 16'd32768;
    else if (cfg_we) thresh <= cfg_data;
  end

  // read address runs one entry ahead so the entry is ready in ST_READ
  assign rd_addr = (state == ST_IDLE) ? '0 :
                   (state == ST_PICK) ? IdxW'(scan + 1'b1) : scan[IdxW-1:0];

  // detection memory: write on load, registered read during scan
  always_ff @(posedge clk) begin
    if (accept && op_t'(op) == OP_LOAD && count < CntW'(MAX_DETECTIONS)) begin
      cls_mem[count[IdxW-1:0]] <= obj_class;
      box_mem[count[IdxW-1:0]] <= '{box_left, box_top, box_right, box_bottom};
    end
    rd_cls  <= cls_mem[rd_addr];
    rd_box  <= box_mem[rd_addr];
    rd_used <= used[rd_addr];
  end

  // intersection and union of read entry and track box
  logic [15:0] ix0, ix1, iy0, iy1;
  logic [15:0] iw, ih;
  logic signed [AreaW-1:0] area_a, area_b;
  always_comb begin
    ix0 = (rd_box.l > trk.l) ? rd_box.l : trk.l;
    ix1 = (rd_box.r < trk.r) ? rd_box.r : trk.r;
    iy0 = (rd_box.t > trk.t) ? rd_box.t : trk.t;
    iy1 = (rd_box.b < trk.b) ? rd_box.b : trk.b;
    iw  = (ix1 > ix0) ? ix1 - ix0 : 16'd0;
    ih  = (iy1 > iy0) ? iy1 - iy0 : 16'd0;
  end

  // areas registered in ST_READ (one multiplier each), then added into the union in ST_AREA
  logic [InterW-1:0] inter_p;
  always_ff @(posedge clk) begin
    if (state == ST_READ) begin
      inter_p <= iw * ih;
      area_a  <= AreaW'(($signed({1'b0, rd_box.r}) - $signed({1'b0, rd_box.l})) *
                        ($signed({1'b0, rd_box.b}) - $signed({1'b0, rd_box.t})));
      area_b  <= AreaW'(($signed({1'b0, trk.r}) - $signed({1'b0, trk.l})) *
                        ($signed({1'b0, trk.b}) - $signed({1'b0, trk.t})));
    end
    if (state == ST_AREA) begin
      inter <= inter_p;
      uni   <= UnionW'(area_a) + UnionW'(area_b) - $signed({3'b0, inter_p});
    end
  end
  assign uni_pos = !uni[UnionW-1] && (uni != '0);

  assign dctl.start = (state == ST_DIV) && !dst.busy && !dst.done && uni_pos;

  gitm_divider u_div (
    .clk(clk), .rst(rst), .ctrl(dctl), .inter(inter),
    .union_val(uni[UnionW-2:0]), .stat(dst), .quot(quot)
  );

  assign cost = uni_pos ? CostW'(17'd65536 - quot) : CostW'(17'd65536);

  // sequencer state and next state
  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  logic cand;
  assign cand = !rd_used && rd_cls == trk_cls;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (accept && op_t'(op) == OP_MATCH) state_next = ST_READ;
      ST_READ: begin
        if (scan >= count) state_next = ST_DONE;
        else state_next = ST_AREA;
      end
      ST_AREA: state_next = cand ? ST_DIV : ST_PICK;
      ST_DIV: if (!uni_pos || dst.done) state_next = ST_PICK;
      ST_PICK: state_next = ST_READ;
      ST_DONE: begin
        if (found && win_cost < CostW'(17'd65536 - {1'b0, thresh})) state_next = ST_OUT;
        else state_next = ST_IDLE;
      end
      ST_OUT: if (!out_stall) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // datapath control
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      used  <= '0;
      found <= 1'b0;
      scan  <= '0;
    end else begin
      if (accept) begin
        unique case (op_t'(op))
          OP_LOAD: if (count < CntW'(MAX_DETECTIONS)) begin
            used[count[IdxW-1:0]] <= 1'b0;
            count <= count + 1'b1;
          end
          OP_END: begin
            count <= '0;
            used  <= '0;
          end
          OP_MATCH: begin
            trk     <= '{box_left, box_top, box_right, box_bottom};
            trk_cls <= obj_class;
            trk_id  <= track_ident;
            found   <= 1'b0;
            scan    <= '0;
          end
          OP_NONE: ;
          default: ;
        endcase
      end
      if (state == ST_PICK) begin
        if (cand && (!found || cost < win_cost)) begin
          found    <= 1'b1;
          win_cost <= cost;
          win_idx  <= scan[IdxW-1:0];
        end
        scan <= scan + 1'b1;
      end
      if (state == ST_DONE && state_next == ST_OUT) used[win_idx] <= 1'b1;
    end
  end

  // result register
  assign out_valid         = (state == ST_OUT);
  assign matched_track     = trk_id;
  assign matched_detection = 6'(win_idx);
  assign match_cost        = win_cost;

endmodule

[verif/greedy_iou_track_matcher_unit_tb.sv]
`timescale 1ns / 1ps

module greedy_iou_track_matcher_unit_tb
  import gitm_pkg::*;
();

  localparam int NumDet = 64;
  localparam int Drain = 4000;
  localparam longint CycleLimit = 64'd8000000;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic [1:0] op;
  logic [7:0] obj_class;
  logic [15:0] box_left, box_top, box_right, box_bottom, track_ident;
  logic out_valid;
  logic out_stall;
  logic [15:0] matched_track;
  logic [5:0] matched_detection;
  logic [16:0] match_cost;
  logic cfg_we;
  logic [15:0] cfg_data;

  greedy_iou_track_matcher_unit u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .op(op), .obj_class(obj_class),
    .box_left(box_left), .box_top(box_top),
    .box_right(box_right), .box_bottom(box_bottom),
    .track_ident(track_ident),
    .out_valid(out_valid), .out_stall(out_stall),
    .matched_track(matched_track), .matched_detection(matched_detection),
    .match_cost(match_cost),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  typedef struct packed {
    op_t op;
    logic [7:0] cls;
    box_t bx;
    logic [15:0] trk;
  } request_t;

  typedef struct packed {
    logic [15:0] trk;
    logic [5:0] det;
    logic [16:0] cost;
  } match_t;

  // directed row: request plus optional typed-in match
  typedef struct {
    request_t req;
    bit has_match;
    match_t m;
  } row_t;

  // predictor state
  logic [7:0] pred_class [NumDet];
  box_t pred_box [NumDet];
  bit pred_used [NumDet];
  int pred_count;
  logic [15:0] pred_thresh;

  match_t match_queue[$];
  request_t send_queue[$];
  row_t rows[$];
  int fails = 0;
  int tbl_fails;
  longint cycles = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  // q1.16 overlap ratio, zero when the union is not positive
  function automatic longint overlap_q16(box_t p, box_t q);
    longint iw, ih, inter, ap, aq, un, v;
    iw = longint'(p.r < q.r ? p.r : q.r) - longint'(p.l > q.l ? p.l : q.l);
    ih = longint'(p.b < q.b ? p.b : q.b) - longint'(p.t > q.t ? p.t : q.t);
    if (iw < 0) iw = 0;
    if (ih < 0) ih = 0;
    inter = iw * ih;
    ap = (longint'(p.r) - longint'(p.l)) * (longint'(p.b) - longint'(p.t));
    aq = (longint'(q.r) - longint'(q.l)) * (longint'(q.b) - longint'(q.t));
    un = ap + aq - inter;
    if (un <= 0) return 0;
    v = (inter * 65536) / un;
    if (v > 65536) v = 65536;
    return v;
  endfunction

  // advance the detection store by one request; returns 1 on a match
  function automatic bit associate_track(request_t r, output match_t m);
    bit found;
    int best;
    longint bc, c;
    found = 1'b0;
    best = 0;
    bc = 0;
    m = '0;
    case (r.op)
      OP_LOAD: begin
        if (pred_count < NumDet) begin
          pred_class[pred_count] = r.cls;
          pred_box[pred_count] = r.bx;
          pred_used[pred_count] = 1'b0;
          pred_count++;
        end
      end
      OP_END: begin
        pred_count = 0;
        foreach (pred_used[i]) pred_used[i] = 1'b0;
      end
      OP_MATCH: begin
        for (int j = 0; j < pred_count; j++) begin
          if (pred_used[j] || pred_class[j] != r.cls) continue;
          c = 65536 - overlap_q16(pred_box[j], r.bx);
          if (!found || c < bc) begin
            found = 1'b1;
            bc = c;
            best = j;
          end
        end
        if (found && bc < 65536 - longint'(pred_thresh)) begin
          pred_used[best] = 1'b1;
          m.trk = r.trk;
          m.det = best[5:0];
          m.cost = bc[16:0];
          return 1'b1;
        end
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  function automatic request_t mk(op_t o, logic [7:0] c, logic [15:0] l, logic [15:0] t,
                                  logic [15:0] r, logic [15:0] b, logic [15:0] k);
    request_t q;
    q.op = o;
    q.cls = c;
    q.bx = '{l: l, t: t, r: r, b: b};
    q.trk = k;
    return q;
  endfunction

  function automatic void add_row(request_t q, bit hm, match_t m);
    row_t w;
    w.req = q;
    w.has_match = hm;
    w.m = m;
    rows = {rows, w};
  endfunction

  // random box, mostly well formed and near a center
  function automatic box_t rand_box(logic [15:0] cx, logic [15:0] cy);
    box_t b;
    int k;
    k = $urandom_range(0, 19);
    if (k == 0) begin
      b.l = 16'($urandom); b.t = 16'($urandom); b.r = 16'($urandom); b.b = 16'($urandom);
    end else begin
      b.l = cx + 16'($urandom_range(0, 40));
      b.t = cy + 16'($urandom_range(0, 40));
      b.r = b.l + 16'($urandom_range(0, 300));
      b.b = b.t + 16'($urandom_range(0, 300));
      if (k == 1) b.r = b.l - 16'($urandom_range(1, 50));
    end
    return b;
  endfunction

  // sender: bursts with random gaps
  task automatic send_all();
    request_t q;
    match_t m;
    int burst, gap;
    burst = 0;
    while (send_queue.size() > 0) begin
      if (burst == 0) begin
        gap = $urandom_range(0, 6);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        burst = $urandom_range(1, 12);
      end
      q = send_queue.pop_front();
      in_valid <= 1'b1;
      op <= q.op;
      obj_class <= q.cls;
      box_left <= q.bx.l;
      box_top <= q.bx.t;
      box_right <= q.bx.r;
      box_bottom <= q.bx.b;
      track_ident <= q.trk;
      @(posedge clk);
      while (in_stall) @(posedge clk);
      if (associate_track(q, m)) match_queue = {match_queue, m};
      burst--;
    end
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_idle();
    while (match_queue.size() > 0) @(posedge clk);
    repeat (Drain) @(posedge clk);
  endtask

  task automatic write_threshold(logic [15:0] v);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    pred_thresh = v;
  endtask

  // receiver stall pattern with quiet stretches
  always @(posedge clk) begin
    if (rst) out_stall <= 1'b0;
    else if (cycles % 3000 < 1000) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(0, 3) == 0);
  end

  // result checker
  always @(posedge clk) begin
    match_t e;
    if (!rst && out_valid && !out_stall) begin
      if (match_queue.size() == 0) begin
        $error("unexpected match track=%0d", matched_track);
        fails++;
      end else begin
        e = match_queue.pop_front();
        if (matched_track !== e.trk) begin
          $error("matched_track exp %0d got %0d", e.trk, matched_track);
          fails++;
        end
        if (matched_detection !== e.det) begin
          $error("matched_detection exp %0d got %0d", e.det, matched_detection);
          fails++;
        end
        if (match_cost !== e.cost) begin
          $error("match_cost exp %0d got %0d", e.cost, match_cost);
          fails++;
        end
      end
    end
  end

  initial begin
    match_t z;
    box_t b;
    logic [7:0] c;
    int n, sent;
    logic [15:0] ths [4];
    ths = '{16'd0, 16'd65535, 16'd20000, 16'd45000};
    tbl_fails = 0;
    rst = 1'b1;
    in_valid = 1'b0;
    op = OP_NONE;
    obj_class = '0;
    box_left = '0; box_top = '0; box_right = '0; box_bottom = '0;
    track_ident = '0;
    cfg_we = 1'b0;
    cfg_data = '0;
    pred_count = 0;
    pred_thresh = 16'd32768;
    foreach (pred_used[i]) pred_used[i] = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table, default threshold
    z = '0;
    add_row(mk(OP_LOAD, 8'd5, 16'd0, 16'd0, 16'd100, 16'd100, 16'd0), 1'b0, z);
    add_row(mk(OP_LOAD, 8'd5, 16'd0, 16'd0, 16'd100, 16'd100, 16'd0), 1'b0, z);
    add_row(mk(OP_LOAD, 8'd255, 16'd65535, 16'd65535, 16'd0, 16'd0, 16'hffff), 1'b0, z);
    add_row(mk(OP_LOAD, 8'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0), 1'b0, z);
    add_row(mk(OP_LOAD, 8'd7, 16'd0, 16'd0, 16'd65535, 16'd65535, 16'd0), 1'b0, z);
    // exact overlap, tie goes to lowest index
    add_row(mk(OP_MATCH, 8'd5, 16'd0, 16'd0, 16'd100, 16'd100, 16'hffff), 1'b1,
            '{trk: 16'hffff, det: 6'd0, cost: 17'd0});
    add_row(mk(OP_MATCH, 8'd5, 16'd0, 16'd0, 16'd100, 16'd100, 16'd1), 1'b1,
            '{trk: 16'd1, det: 6'd1, cost: 17'd0});
    // all same-class detections used: no match
    add_row(mk(OP_MATCH, 8'd5, 16'd0, 16'd0, 16'd100, 16'd100, 16'd2), 1'b0, z);
    // inverted box and zero union
    add_row(mk(OP_MATCH, 8'd255, 16'd65535, 16'd65535, 16'd0, 16'd0, 16'd3), 1'b0, z);
    add_row(mk(OP_MATCH, 8'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd4), 1'b0, z);
    // full-range box
    add_row(mk(OP_MATCH, 8'd7, 16'd0, 16'd0, 16'd65535, 16'd65535, 16'haaaa), 1'b1,
            '{trk: 16'haaaa, det: 6'd4, cost: 17'd0});
    add_row(mk(OP_MATCH, 8'd9, 16'd0, 16'd0, 16'd10, 16'd10, 16'd5), 1'b0, z);
    add_row(mk(OP_NONE, 8'd5, 16'd1, 16'd1, 16'd2, 16'd2, 16'd6), 1'b0, z);
    add_row(mk(OP_END, 8'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0), 1'b0, z);
    add_row(mk(OP_MATCH, 8'd5, 16'd0, 16'd0, 16'd100, 16'd100, 16'd7), 1'b0, z);
    // partial overlap, predicted
    add_row(mk(OP_LOAD, 8'd3, 16'd10, 16'd10, 16'd60, 16'd60, 16'd0), 1'b0, z);
    add_row(mk(OP_MATCH, 8'd3, 16'd20, 16'd15, 16'd65, 16'd62, 16'd8), 1'b0, z);
    foreach (rows[i]) begin
      send_queue = {send_queue, rows[i].req};
      send_all();
      if (rows[i].has_match) begin
        if (match_queue.size() == 0 || match_queue[$] !== rows[i].m) begin
          $error("directed row %0d match differs from table", i);
          tbl_fails++;
        end
      end
    end
    wait_idle();

    // store overflow: 66 loads, last ones dropped
    send_queue = {send_queue, mk(OP_END, 8'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0)};
    for (int i = 0; i < 66; i++)
      send_queue = {send_queue, mk(OP_LOAD, 8'd1, i[15:0], 16'd0, i[15:0] + 16'd10,
                                   16'd10, 16'd0)};
    send_queue = {send_queue, mk(OP_MATCH, 8'd1, 16'd65, 16'd0, 16'd75, 16'd10, 16'd9)};
    send_queue = {send_queue, mk(OP_MATCH, 8'd1, 16'd63, 16'd0, 16'd73, 16'd10, 16'd10)};
    send_all();
    wait_idle();

    // random frames across thresholds
    sent = 0;
    for (int ph = 0; ph < 4; ph++) begin
      write_threshold(ths[ph]);
      while (sent < (ph + 1) * 110) begin
        send_queue = {send_queue, mk(OP_END, 8'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0)};
        n = $urandom_range(1, 8);
        for (int i = 0; i < n; i++) begin
          c = 8'($urandom_range(0, 2));
          if ($urandom_range(0, 15) == 0) c = 8'($urandom);
          b = rand_box(16'($urandom_range(0, 600)), 16'($urandom_range(0, 600)));
          if ($urandom_range(0, 9) == 0) b = rand_box(16'($urandom), 16'($urandom));
          send_queue = {send_queue, mk(OP_LOAD, c, b.l, b.t, b.r, b.b, 16'($urandom))};
        end
        for (int i = 0; i < n + 1; i++) begin
          request_t q;
          q = send_queue[$urandom_range(send_queue.size() - n, send_queue.size() - 1)];
          if (q.op != OP_LOAD) q = send_queue[send_queue.size() - 1];
          q.op = OP_MATCH;
          q.trk = 16'($urandom);
          q.bx.l += 16'($urandom_range(0, 12));
          q.bx.r += 16'($urandom_range(0, 12));
          q.bx.t -= 16'($urandom_range(0, 12));
          if ($urandom_range(0, 7) == 0) q.cls = 8'($urandom);
          send_queue = {send_queue, q};
        end
        if ($urandom_range(0, 9) == 0)
          send_queue = {send_queue, mk(op_t'($urandom_range(0, 3)), 8'($urandom),
                                       16'($urandom), 16'($urandom), 16'($urandom),
                                       16'($urandom), 16'($urandom))};
        sent += send_queue.size();
        send_all();
      end
      wait_idle();
    end
    write_threshold(16'd32768);

    if (fails == 0 && tbl_fails == 0 && match_queue.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[files.f]
src/gitm_pkg.sv
src/gitm_divider.sv
src/greedy_iou_track_matcher_unit.sv
verif/greedy_iou_track_matcher_unit_tb.sv
